[design/windowed_entropy_autocorrelation_core_assert.svh]
// Assertion macros for the windowed entropy autocorrelation core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef WINDOWED_ENTROPY_AUTOCORRELATION_CORE_ASSERT_SVH
`define WINDOWED_ENTROPY_AUTOCORRELATION_CORE_ASSERT_SVH

// Same-cycle implication.
`define WEA_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wea_pkg.sv]
// Shared constants, codes and state type of the windowed entropy autocorrelation core.
// No dependencies.
package wea_pkg;

	localparam int FRAC_BITS          = 16;
	localparam int MAX_WINDOW         = 4096;
	localparam int MAX_SUBWINDOW_SIZE = 256;
	localparam int MAX_SUBWINDOWS_DEF = 64;

	localparam int WIN_W     = 13;
	localparam int SUB_W     = 9;
	localparam int ENT_W     = FRAC_BITS + 2;
	localparam int LOG_INT_W = $clog2(SUB_W);
	localparam int LOG_W     = LOG_INT_W + FRAC_BITS;
	localparam int T_W       = SUB_W + LOG_W + 2;
	localparam int MANT_FB   = 30;
	localparam int MANT_W    = MANT_FB + 1;
	localparam int NUM_W     = 32;
	localparam int RES_W     = 20;
	localparam int STAT_W    = 2;

	localparam logic [RES_W-1:0] OUT_SAT = {RES_W{1'b1}};
	localparam logic [ENT_W-1:0] ENT_MAX = {ENT_W{1'b1}};

	localparam logic [0:0] CFG_WINDOW    = 1'b0;
	localparam logic [0:0] CFG_SUBWINDOW = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FEW  = 2'd1,
		STAT_FLAT = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CNT_SEL,
		ST_CNT_LOG,
		ST_CNT_ACC,
		ST_LN_START,
		ST_LN_WAIT,
		ST_ENT_START,
		ST_ENT_DIV,
		ST_ACF_CHECK,
		ST_SUM,
		ST_MEAN_START,
		ST_MEAN_DIV,
		ST_VAR,
		ST_LAG,
		ST_FRAC0,
		ST_FRAC1,
		ST_FRAC_STEP,
		ST_TERM_START,
		ST_TERM_DIV,
		ST_RES_START,
		ST_RES_DIV,
		ST_EMIT
	} state_t;

endpackage

[design/wea_in_if.sv]
// Input channel of the core: one base code per beat.
// No dependencies.
interface wea_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] base;
	logic       end_of_data;

	modport source (output valid, output base, output end_of_data, input ready);
	modport sink (input valid, input base, input end_of_data, output ready);
endinterface

[design/wea_out_if.sv]
// Result channel of the core: one beat per closed window.
// No dependencies.
interface wea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] window_number;
	logic [19:0] correlated_entropy;
	logic [1:0]  status;

	modport source (output valid, output window_number, output correlated_entropy,
		output status, input ready);
	modport sink (input valid, input window_number, input correlated_entropy,
		input status, output ready);
endinterface

[design/wea_store.sv]
// Entropy store: synchronous memory, one write port and two registered read ports.
// Depends on nothing but its parameters.
module wea_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_a,
	output logic [W-1:0]  rdata_b
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

[design/wea_log2.sv]
// Iterative fixed-point log2: one mantissa squaring per cycle, FRAC_BITS fraction bits.
// Depends on wea_pkg.
module wea_log2 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wea_pkg::SUB_W-1:0]  x,
	output logic                       busy,
	output logic                       done,
	output logic [wea_pkg::LOG_W-1:0]  value
);
	import wea_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [LOG_INT_W-1:0]      msb;
	logic [SUB_W+MANT_FB-1:0]  mant_wide;
	logic [2*MANT_W-1:0]       sq;
	logic [MANT_W:0]           m2;
	logic [LOG_INT_W-1:0]      msb_q;
	logic [MANT_W-1:0]         mant_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;

	always_comb begin
		msb = '0;
		for (int b = 0; b < SUB_W; b++) begin
			if (x[b]) begin
				msb = LOG_INT_W'(b);
			end
		end
		mant_wide = {x, {MANT_FB{1'b0}}} >> msb;
		sq        = mant_q * mant_q;
		m2        = sq[2*MANT_W-1:MANT_FB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			msb_q  <= '0;
			mant_q <= '0;
			frac_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				msb_q  <= msb;
				mant_q <= mant_wide[MANT_W-1:0];
				frac_q <= '0;
			end else if (busy_q) begin
				// square of two or more: emit a one and halve
				if (m2[MANT_W]) begin
					mant_q <= m2[MANT_W:1];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					mant_q <= m2[MANT_W-1:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign value = {msb_q, frac_q};
endmodule

[design/wea_div.sv]
// Restoring divider, one quotient bit per cycle, DW quotient bits per division.
// Depends on nothing but its parameters; divisor must be nonzero.
module wea_div #(
	parameter int DW = 32,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] dvs_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, dvd_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvs_q  <= divisor;
				rem_q  <= '0;
				dvd_q  <= dividend;
			end else if (busy_q) begin
				// quotient bits shift in where dividend bits leave
				if (fits) begin
					rem_q <= VW'(shifted - {1'b0, dvs_q});
				end else begin
					rem_q <= shifted[VW-1:0];
				end
				dvd_q <= {dvd_q[DW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

[design/windowed_entropy_autocorrelation_core.sv]
// Windowed entropy autocorrelation core.
// sample (sink): one base code per beat, with end_of_data closing the window after it.
// result (source): one beat per closed window with window_number, correlated_entropy
// (unsigned Q4.16, saturated) and status (ok, fewer than two subwindows, zero variance).
// cfg_write/cfg_index/cfg_data: index 0 window length, index 1 subwindow length; write
// only while the core is idle.
// A base that closes nothing leaves the core idle, ready for the next base. A base that
// closes a subwindow also runs the log2 unit and divider. A closing window with N >= 2
// stored entropies adds the sum, mean and variance passes and, unless the variance is zero,
// the lag passes, paced by the single store read pair per cycle for the lag products and
// the shared bit-serial divider.
// Result is registered: the core takes new bases while a result waits; a new result waits
// in the emit step until the previous one is taken.
// Reset: registers return to their reset values, counts and fills clear, the window
// counter restarts; the entropy store needs no clearing.
`include "windowed_entropy_autocorrelation_core_assert.svh"
module windowed_entropy_autocorrelation_core #(
	parameter int MAX_SUBWINDOWS = wea_pkg::MAX_SUBWINDOWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	wea_in_if.sink                    sample,
	wea_out_if.source                 result,
	input  logic                      cfg_write,
	input  logic [0:0]                cfg_index,
	input  logic [wea_pkg::WIN_W-1:0] cfg_data
);
	import wea_pkg::*;

	localparam int NW     = $clog2(MAX_SUBWINDOWS + 1);
	localparam int AW     = $clog2(MAX_SUBWINDOWS);
	localparam int DEV_W  = ENT_W + 1;
	localparam int PRD_W  = 2 * DEV_W;
	localparam int ACC_W  = PRD_W + NW;
	localparam int SUMS_W = ENT_W + NW;
	localparam int F_W    = FRAC_BITS + 1;
	localparam int FN_W   = F_W + NW;
	localparam int TSUM_W = F_W + 2 * NW;
	localparam int DIV_A  = (T_W > TSUM_W) ? T_W : TSUM_W;
	localparam int DIV_W  = (DIV_A > SUMS_W) ? DIV_A : SUMS_W;
	localparam int VW     = (SUB_W > NW) ? SUB_W : NW;
	localparam int JW     = $clog2(FRAC_BITS + 1);

	state_t state_q, state_d;

	logic [WIN_W-1:0] wsz_q, wsz_eff;
	logic [SUB_W-1:0] ssz_q, ssz_eff;

	logic [SUB_W-1:0] cnt_q [4];
	logic [SUB_W-1:0] sf_q, sf_inc;
	logic [WIN_W-1:0] wf_q, wf_inc;
	logic [NW-1:0]    idx_q;
	logic [NUM_W-1:0] wcnt_q;
	logic             win_pend_q;
	logic [1:0]       b_q;
	logic [T_W-1:0]   t_q;
	logic [SUB_W+LOG_W-1:0] prod_q;
	logic [LOG_W-1:0] ln_q;
	logic [SUMS_W-1:0] s_q;
	logic [ENT_W-1:0] mean_q;
	logic [ACC_W-1:0] qv_q;
	logic signed [ACC_W-1:0] p_q;
	logic [NW-1:0]    i_q, k_q, lim;
	logic             v_s1, v_s2;
	logic signed [PRD_W-1:0] prd_s2;
	logic [ACC_W:0]   rem_q;
	logic [F_W-1:0]   f_q;
	logic [JW-1:0]    j_q;
	logic [TSUM_W-1:0] tsum_q;
	logic [RES_W-1:0] res_q;
	status_t          stat_q;

	logic             out_v_q;
	logic [NUM_W-1:0] out_num_q;
	logic [RES_W-1:0] out_res_q;
	status_t          out_stat_q;

	logic             acc, sub_close, win_close, emit_go, issue, rd_done, store_ok;
	logic             log_start, log_busy, log_done;
	logic [SUB_W-1:0] log_x;
	logic [LOG_W-1:0] log_val;
	logic             div_start, div_busy, div_done;
	logic [DIV_W-1:0] div_dvd, div_quot;
	logic [VW-1:0]    div_dvs;
	logic             mem_we;
	logic [ENT_W-1:0] h_val, ra, rb;
	logic [LOG_W-1:0] diff;
	logic [NW-1:0]    addr_b;
	logic signed [DEV_W-1:0] da, db;
	logic signed [PRD_W-1:0] prd;
	logic [ACC_W-1:0] p_abs;
	logic [ACC_W:0]   rem_sh;
	logic [FN_W-1:0]  fn;

	// clamp register values to their usable range
	always_comb begin
		wsz_eff = wsz_q;
		if (wsz_q == '0) begin
			wsz_eff = WIN_W'(1);
		end else if (wsz_q > WIN_W'(MAX_WINDOW)) begin
			wsz_eff = WIN_W'(MAX_WINDOW);
		end
		ssz_eff = ssz_q;
		if (ssz_q == '0) begin
			ssz_eff = SUB_W'(1);
		end else if (ssz_q > SUB_W'(MAX_SUBWINDOW_SIZE)) begin
			ssz_eff = SUB_W'(MAX_SUBWINDOW_SIZE);
		end
	end

	assign acc       = sample.valid && sample.ready;
	assign sf_inc    = sf_q + 1'b1;
	assign wf_inc    = wf_q + 1'b1;
	assign sub_close = sf_inc >= ssz_eff;
	assign win_close = sample.end_of_data || (wf_inc >= wsz_eff);
	assign emit_go   = !out_v_q || result.ready;
	assign store_ok  = idx_q < NW'(MAX_SUBWINDOWS);
	assign lim       = (state_q == ST_LAG) ? (idx_q - k_q) : idx_q;
	assign issue     = ((state_q == ST_SUM) || (state_q == ST_VAR) || (state_q == ST_LAG))
		&& (i_q < lim);
	assign rd_done   = (i_q == lim) && !v_s1 && !v_s2;
	assign addr_b    = i_q + k_q;

	// entropy of the closing subwindow, clamped
	always_comb begin
		diff  = ln_q - div_quot[LOG_W-1:0];
		h_val = ENT_MAX;
		if (div_quot > DIV_W'(ln_q)) begin
			h_val = '0;
		end else if (diff <= LOG_W'(ENT_MAX)) begin
			h_val = diff[ENT_W-1:0];
		end
	end

	assign da     = $signed({1'b0, ra}) - $signed({1'b0, mean_q});
	assign db     = $signed({1'b0, rb}) - $signed({1'b0, mean_q});
	assign prd    = (state_q == ST_LAG) ? (da * db) : (da * da);
	assign p_abs  = p_q[ACC_W-1] ? ACC_W'(-p_q) : ACC_W'(p_q);
	assign rem_sh = {rem_q[ACC_W-1:0], 1'b0};
	assign fn     = FN_W'(f_q * idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (sub_close || win_close)) begin
					state_d = ST_CNT_SEL;
				end
			end
			ST_CNT_SEL: begin
				if (cnt_q[b_q] != '0) begin
					state_d = ST_CNT_LOG;
				end else if (b_q == 2'd3) begin
					state_d = ST_LN_START;
				end
			end
			ST_CNT_LOG: if (log_done) state_d = ST_CNT_ACC;
			ST_CNT_ACC: state_d = (b_q == 2'd3) ? ST_LN_START : ST_CNT_SEL;
			ST_LN_START: state_d = ST_LN_WAIT;
			ST_LN_WAIT: if (log_done) state_d = ST_ENT_START;
			ST_ENT_START: state_d = ST_ENT_DIV;
			ST_ENT_DIV: begin
				if (div_done) begin
					state_d = win_pend_q ? ST_ACF_CHECK : ST_IDLE;
				end
			end
			ST_ACF_CHECK: state_d = (idx_q < NW'(2)) ? ST_EMIT : ST_SUM;
			ST_SUM: if (rd_done) state_d = ST_MEAN_START;
			ST_MEAN_START: state_d = ST_MEAN_DIV;
			ST_MEAN_DIV: if (div_done) state_d = ST_VAR;
			ST_VAR: begin
				if (rd_done) begin
					state_d = (qv_q == '0) ? ST_EMIT : ST_LAG;
				end
			end
			ST_LAG: if (rd_done) state_d = ST_FRAC0;
			ST_FRAC0: state_d = ST_FRAC1;
			ST_FRAC1: state_d = ST_FRAC_STEP;
			ST_FRAC_STEP: if (j_q == JW'(FRAC_BITS - 1)) state_d = ST_TERM_START;
			ST_TERM_START: state_d = ST_TERM_DIV;
			ST_TERM_DIV: begin
				if (div_done) begin
					state_d = ((k_q + 1'b1) == idx_q) ? ST_RES_START : ST_LAG;
				end
			end
			ST_RES_START: state_d = ST_RES_DIV;
			ST_RES_DIV: if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (emit_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		sample.ready = (state_q == ST_IDLE);
		log_start    = 1'b0;
		log_x        = sf_q;
		div_start    = 1'b0;
		div_dvd      = DIV_W'(t_q);
		div_dvs      = VW'(sf_q);
		mem_we       = (state_q == ST_ENT_DIV) && div_done && store_ok;
		case (state_q)
			ST_CNT_SEL: begin
				log_start = (cnt_q[b_q] != '0);
				log_x     = cnt_q[b_q];
			end
			ST_LN_START: log_start = 1'b1;
			ST_ENT_START: div_start = 1'b1;
			ST_MEAN_START: begin
				div_start = 1'b1;
				div_dvd   = DIV_W'(s_q);
				div_dvs   = VW'(idx_q);
			end
			ST_TERM_START: begin
				div_start = 1'b1;
				div_dvd   = DIV_W'(fn);
				div_dvs   = VW'(idx_q - k_q);
			end
			ST_RES_START: begin
				div_start = 1'b1;
				div_dvd   = DIV_W'(tsum_q);
				div_dvs   = VW'(idx_q - 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wsz_q      <= WIN_W'(1024);
			ssz_q      <= SUB_W'(64);
			for (int b = 0; b < 4; b++) cnt_q[b] <= '0;
			sf_q       <= '0;
			wf_q       <= '0;
			idx_q      <= '0;
			wcnt_q     <= '0;
			win_pend_q <= 1'b0;
			b_q        <= '0;
			t_q        <= '0;
			prod_q     <= '0;
			ln_q       <= '0;
			s_q        <= '0;
			mean_q     <= '0;
			qv_q       <= '0;
			p_q        <= '0;
			i_q        <= '0;
			k_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			prd_s2     <= '0;
			rem_q      <= '0;
			f_q        <= '0;
			j_q        <= '0;
			tsum_q     <= '0;
			res_q      <= '0;
			stat_q     <= STAT_OK;
			out_v_q    <= 1'b0;
			out_num_q  <= '0;
			out_res_q  <= '0;
			out_stat_q <= STAT_OK;
		end else begin
			state_q <= state_d;

			if (cfg_write) begin
				if (cfg_index == CFG_WINDOW) begin
					wsz_q <= cfg_data;
				end else begin
					ssz_q <= cfg_data[SUB_W-1:0];
				end
			end

			// drop the taken beat unless the emit step reloads it
			if (out_v_q && result.ready && !((state_q == ST_EMIT) && emit_go)) begin
				out_v_q <= 1'b0;
			end

			// read pipeline shared by the sum, variance and lag passes
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q != ST_SUM);
			if (issue) begin
				i_q <= i_q + 1'b1;
			end
			if (v_s1) begin
				prd_s2 <= prd;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q[sample.base] <= cnt_q[sample.base] + 1'b1;
						sf_q       <= sf_inc;
						wf_q       <= wf_inc;
						win_pend_q <= win_close;
						b_q        <= '0;
						t_q        <= '0;
					end
				end
				ST_CNT_SEL: begin
					if ((cnt_q[b_q] == '0) && (b_q != 2'd3)) begin
						b_q <= b_q + 1'b1;
					end
				end
				ST_CNT_LOG: begin
					if (log_done) begin
						prod_q <= cnt_q[b_q] * log_val;
					end
				end
				ST_CNT_ACC: begin
					t_q <= t_q + T_W'(prod_q);
					if (b_q != 2'd3) begin
						b_q <= b_q + 1'b1;
					end
				end
				ST_LN_WAIT: begin
					if (log_done) begin
						ln_q <= log_val;
					end
				end
				ST_ENT_DIV: begin
					if (div_done) begin
						if (store_ok) begin
							idx_q <= idx_q + 1'b1;
						end
						for (int b = 0; b < 4; b++) cnt_q[b] <= '0;
						sf_q <= '0;
					end
				end
				ST_ACF_CHECK: begin
					i_q    <= '0;
					k_q    <= NW'(1);
					s_q    <= '0;
					qv_q   <= '0;
					p_q    <= '0;
					tsum_q <= '0;
					res_q  <= '0;
					stat_q <= (idx_q < NW'(2)) ? STAT_FEW : STAT_OK;
				end
				ST_SUM: begin
					if (v_s1) begin
						s_q <= s_q + SUMS_W'(ra);
					end
				end
				ST_MEAN_DIV: begin
					if (div_done) begin
						mean_q <= div_quot[ENT_W-1:0];
						i_q    <= '0;
					end
				end
				ST_VAR: begin
					if (v_s2) begin
						qv_q <= qv_q + ACC_W'($unsigned(prd_s2));
					end
					if (rd_done) begin
						i_q <= '0;
						if (qv_q == '0) begin
							stat_q <= STAT_FLAT;
						end
					end
				end
				ST_LAG: begin
					if (v_s2) begin
						p_q <= p_q + {{NW{prd_s2[PRD_W-1]}}, prd_s2};
					end
				end
				ST_FRAC0: begin
					if (p_abs >= qv_q) begin
						f_q   <= F_W'(1);
						rem_q <= {1'b0, p_abs - qv_q};
					end else begin
						f_q   <= '0;
						rem_q <= {1'b0, p_abs};
					end
				end
				ST_FRAC1: begin
					if (rem_q >= {1'b0, qv_q}) begin
						rem_q <= '0;
					end
					j_q <= '0;
				end
				ST_FRAC_STEP: begin
					if (rem_sh >= {1'b0, qv_q}) begin
						rem_q <= rem_sh - {1'b0, qv_q};
						f_q   <= {f_q[F_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						f_q   <= {f_q[F_W-2:0], 1'b0};
					end
					j_q <= j_q + 1'b1;
				end
				ST_TERM_DIV: begin
					if (div_done) begin
						tsum_q <= tsum_q + TSUM_W'(div_quot);
						k_q    <= k_q + 1'b1;
						i_q    <= '0;
						p_q    <= '0;
					end
				end
				ST_RES_DIV: begin
					if (div_done) begin
						res_q <= (div_quot > DIV_W'(OUT_SAT)) ? OUT_SAT : div_quot[RES_W-1:0];
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_v_q    <= 1'b1;
						out_num_q  <= wcnt_q + 1'b1;
						out_res_q  <= res_q;
						out_stat_q <= stat_q;
						wcnt_q     <= wcnt_q + 1'b1;
						wf_q       <= '0;
						idx_q      <= '0;
						win_pend_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid              = out_v_q;
	assign result.window_number      = out_num_q;
	assign result.correlated_entropy = out_res_q;
	assign result.status             = out_stat_q;

	wea_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.busy   (log_busy),
		.done   (log_done),
		.value  (log_val)
	);

	wea_div #(
		.DW (DIV_W),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	wea_store #(
		.DEPTH (MAX_SUBWINDOWS),
		.AW    (AW),
		.W     (ENT_W)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (idx_q[AW-1:0]),
		.wdata   (h_val),
		.raddr_a (i_q[AW-1:0]),
		.raddr_b (addr_b[AW-1:0]),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	`WEA_ASSERT_HOLDS(a_div_start_idle, div_start, !div_busy, "divider started while busy")
	`WEA_ASSERT_HOLDS(a_log_start_idle, log_start, !log_busy, "log2 unit started while busy")
	`WEA_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT) && emit_go, result.valid, "result not loaded")
	`WEA_ASSERT_HOLDS(a_fill_bound, 1'b1, sf_q <= SUB_W'(MAX_SUBWINDOW_SIZE), "subwindow overfill")
endmodule
